// ----- hdl/pwm_prescaler_period_solver_unit_assert.svh -----
// Assertion macros for the PWM prescaler/period solver.
// Expects clk and rst in the scope of use; no other dependencies.
`ifndef PWM_PRESCALER_PERIOD_SOLVER_UNIT_ASSERT_SVH
`define PWM_PRESCALER_PERIOD_SOLVER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define PPS_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pps: implication check failed");

// Next-cycle implication.
`define PPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pps: next-cycle check failed");

`endif

// ----- hdl/pps_pkg.sv -----
// Types, constants and microcode ROM of the PWM prescaler/period solver.
// No dependencies.
package pps_pkg;

  localparam int unsigned DATA_W   = 32;
  localparam int unsigned CNT_W    = 16;
  localparam int unsigned DIVR_W   = DATA_W + CNT_W + 1;
  localparam int unsigned DCNT_W   = $clog2(DATA_W);
  localparam int unsigned STEP_W   = 3;
  localparam logic [DATA_W-1:0] CLK_RESET = 32'd84000000;

  typedef logic [STEP_W-1:0] step_t;

  localparam step_t STEP_WAIT     = 3'd0;
  localparam step_t STEP_CHECK    = 3'd1;
  localparam step_t STEP_DIV1     = 3'd2;
  localparam step_t STEP_SAVE_PSC = 3'd3;
  localparam step_t STEP_MUL      = 3'd4;
  localparam step_t STEP_DIV2     = 3'd5;
  localparam step_t STEP_SAVE_PER = 3'd6;
  localparam step_t STEP_EMIT     = 3'd7;

  typedef enum logic [2:0] {
    OP_LOAD_IN,
    OP_DIV_INIT1,
    OP_DIV_STEP,
    OP_SAVE_PSC,
    OP_DIV_INIT2,
    OP_SAVE_PER,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_TXN,
    COND_BAD_REQ,
    COND_DIV_LAST,
    COND_PSC_OVF,
    COND_OUT_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target_true;
    step_t target_false;
  } ctrl_t;

  function automatic ctrl_t ucode(step_t step);
    ctrl_t cw;
    unique case (step)
      STEP_WAIT:     cw = '{OP_LOAD_IN,   COND_IN_TXN,   STEP_CHECK,    STEP_WAIT};
      STEP_CHECK:    cw = '{OP_DIV_INIT1, COND_BAD_REQ,  STEP_EMIT,     STEP_DIV1};
      STEP_DIV1:     cw = '{OP_DIV_STEP,  COND_DIV_LAST, STEP_SAVE_PSC, STEP_DIV1};
      STEP_SAVE_PSC: cw = '{OP_SAVE_PSC,  COND_PSC_OVF,  STEP_EMIT,     STEP_MUL};
      STEP_MUL:      cw = '{OP_DIV_INIT2, COND_ALWAYS,   STEP_DIV2,     STEP_DIV2};
      STEP_DIV2:     cw = '{OP_DIV_STEP,  COND_DIV_LAST, STEP_SAVE_PER, STEP_DIV2};
      STEP_SAVE_PER: cw = '{OP_SAVE_PER,  COND_ALWAYS,   STEP_EMIT,     STEP_EMIT};
      STEP_EMIT:     cw = '{OP_EMIT,      COND_OUT_BUSY, STEP_EMIT,     STEP_WAIT};
      default:       cw = '{OP_EMIT,      COND_ALWAYS,   STEP_WAIT,     STEP_WAIT};
    endcase
    return cw;
  endfunction

endpackage

// ----- hdl/pwm_prescaler_period_solver_unit.sv -----
// PWM prescaler/period solver. For a requested frequency it returns the
// smallest prescaler p with clock/(freq*(p+1))-1 within 16 bits, the period
// and an ok flag; zero, too high or too low frequencies give ok=0 with zeros.
// One transaction at a time, run by a microcode ROM over two 32-step restoring
// divisions on one shared divider; a zero or too high frequency goes from the
// check step straight to emit, a too low one after the first division. The
// input stays stalled until the sequencer is back in its wait step. A new
// request is taken while the previous result waits; a result that is still
// stalled when the next one is ready holds the sequencer in its emit step.
// Depends on pps_pkg and pwm_prescaler_period_solver_unit_assert.svh.
`include "pwm_prescaler_period_solver_unit_assert.svh"

module pwm_prescaler_period_solver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] req_freq,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] prescaler,
  output logic [15:0] period,
  output logic        ok
);

  logic [pps_pkg::DATA_W-1:0] clk_rate;
  pps_pkg::step_t             step, step_next;
  pps_pkg::ctrl_t             cw;
  logic                       cond_hit;
  logic                       in_txn;
  logic                       out_busy;

  logic [pps_pkg::DATA_W-1:0] freq;
  logic [pps_pkg::DATA_W-1:0] rem;
  logic [pps_pkg::DATA_W-1:0] quo;
  logic [pps_pkg::DIVR_W-1:0] divisor;
  logic [pps_pkg::DCNT_W-1:0] div_cnt;
  logic [pps_pkg::CNT_W-1:0]  res_psc;
  logic [pps_pkg::CNT_W-1:0]  res_per;
  logic                       res_ok;

  logic [pps_pkg::DATA_W:0]   shifted;
  logic                       sub_ok;
  logic [pps_pkg::DIVR_W-1:0] diff;

  assign in_stall = (step != pps_pkg::STEP_WAIT);
  assign in_txn   = in_valid && !in_stall;
  assign out_busy = out_valid && out_stall;
  assign cw       = pps_pkg::ucode(step);

  // one restoring division step
  assign shifted = {rem, quo[pps_pkg::DATA_W-1]};
  assign sub_ok  = {{(pps_pkg::DIVR_W-pps_pkg::DATA_W-1){1'b0}}, shifted} >= divisor;
  assign diff    = {{(pps_pkg::DIVR_W-pps_pkg::DATA_W-1){1'b0}}, shifted} - divisor;

  always_comb begin
    unique case (cw.cond)
      pps_pkg::COND_ALWAYS:   cond_hit = 1'b1;
      pps_pkg::COND_IN_TXN:   cond_hit = in_txn;
      pps_pkg::COND_BAD_REQ:  cond_hit = (freq == '0) || (freq > clk_rate);
      pps_pkg::COND_DIV_LAST: cond_hit = (div_cnt == {pps_pkg::DCNT_W{1'b1}});
      pps_pkg::COND_PSC_OVF:  cond_hit = (quo[pps_pkg::DATA_W-1:pps_pkg::CNT_W] != '0);
      pps_pkg::COND_OUT_BUSY: cond_hit = out_busy;
      default:                cond_hit = 1'b1;
    endcase
    step_next = cond_hit ? cw.target_true : cw.target_false;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= pps_pkg::STEP_WAIT;
      clk_rate <= pps_pkg::CLK_RESET;
    end else begin
      step <= step_next;
      if (cfg_wr_en) begin
        clk_rate <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cw.op == pps_pkg::OP_EMIT && !out_busy) begin
      out_valid <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    unique case (cw.op)
      pps_pkg::OP_LOAD_IN: begin
        if (in_txn) begin
          freq    <= req_freq;
          res_psc <= '0;
          res_per <= '0;
          res_ok  <= 1'b0;
        end
      end
      pps_pkg::OP_DIV_INIT1: begin
        rem     <= '0;
        quo     <= clk_rate;
        div_cnt <= '0;
        divisor <= {1'b0, freq, {pps_pkg::CNT_W{1'b0}}}
                 + {{(pps_pkg::DIVR_W-pps_pkg::DATA_W){1'b0}}, freq};
      end
      pps_pkg::OP_DIV_STEP: begin
        div_cnt <= div_cnt + 1'b1;
        if (sub_ok) begin
          rem <= diff[pps_pkg::DATA_W-1:0];
          quo <= {quo[pps_pkg::DATA_W-2:0], 1'b1};
        end else begin
          rem <= shifted[pps_pkg::DATA_W-1:0];
          quo <= {quo[pps_pkg::DATA_W-2:0], 1'b0};
        end
      end
      pps_pkg::OP_SAVE_PSC: begin
        if (quo[pps_pkg::DATA_W-1:pps_pkg::CNT_W] == '0) begin
          res_psc <= quo[pps_pkg::CNT_W-1:0];
        end
      end
      pps_pkg::OP_DIV_INIT2: begin
        rem     <= '0;
        quo     <= clk_rate;
        div_cnt <= '0;
        divisor <= {{(pps_pkg::DIVR_W-pps_pkg::DATA_W){1'b0}}, freq}
                 * {{(pps_pkg::DIVR_W-pps_pkg::CNT_W-1){1'b0}}, {1'b0, res_psc} + 17'd1};
      end
      pps_pkg::OP_SAVE_PER: begin
        res_per <= quo[pps_pkg::CNT_W-1:0] - 1'b1;
        res_ok  <= 1'b1;
      end
      pps_pkg::OP_EMIT: begin
        if (!out_busy) begin
          prescaler <= res_psc;
          period    <= res_per;
          ok        <= res_ok;
        end
      end
      default: begin
      end
    endcase
  end

  `PPS_ASSERT_IMPLY(a_fail_zeroes, out_valid && !ok, prescaler == '0 && period == '0)
  `PPS_ASSERT_NEXT(a_accept_to_check, in_txn, step == pps_pkg::STEP_CHECK)
  `PPS_ASSERT_NEXT(a_div1_exit, step == pps_pkg::STEP_DIV1 && div_cnt == '1, step == pps_pkg::STEP_SAVE_PSC)

endmodule

// ----- tb/pwm_prescaler_period_solver_unit_tb.sv -----
// Self-checking testbench for pwm_prescaler_period_solver_unit.
// Predicts prescaler/period/ok per frequency request and checks every result;
// most phases add random idling on both channels. Depends on pps_pkg and the RTL.
module pwm_prescaler_period_solver_unit_tb;

  localparam longint unsigned COUNT_LIMIT = (64'd1 << pps_pkg::CNT_W) - 1;
  localparam int QUIET_LIMIT = 4000;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 75;

  typedef struct packed {
    logic [15:0] psc;
    logic [15:0] per;
    logic        ok;
  } timer_setting_t;

  class timer_setting_checker;
    logic [31:0]    clock_hz;
    timer_setting_t pending_settings[$];
    int unsigned    mismatches;

    function new();
      clock_hz = pps_pkg::CLK_RESET;
      mismatches = 0;
    endfunction

    function timer_setting_t solve_setting(logic [31:0] freq);
      timer_setting_t s;
      logic [63:0] clk64;
      logic [63:0] psc;
      logic [63:0] q;
      s = '0;
      clk64 = {32'd0, clock_hz};
      if (freq == 32'd0 || freq > clock_hz) return s;
      psc = clk64 / ((COUNT_LIMIT + 64'd2) * {32'd0, freq});
      if (psc > COUNT_LIMIT) return s;
      q = clk64 / ({32'd0, freq} * (psc + 64'd1));
      q = q - 64'd1;
      s.psc = psc[15:0];
      s.per = q[15:0];
      s.ok = 1'b1;
      return s;
    endfunction

    function void note_request(logic [31:0] freq);
      pending_settings.push_back(solve_setting(freq));
    endfunction

    function void check_setting(logic [15:0] psc, logic [15:0] per, logic okf);
      timer_setting_t want;
      if (pending_settings.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: psc=%0d per=%0d ok=%b", psc, per, okf);
        mismatches++;
        return;
      end
      want = pending_settings.pop_front();
      if (psc !== want.psc || per !== want.per || okf !== want.ok) begin
        if (mismatches < 10)
          $display("mismatch: psc exp %0d got %0d, per exp %0d got %0d, ok exp %b got %b",
                   want.psc, psc, want.per, per, want.ok, okf);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en = 1'b0;
  logic [31:0] cfg_wr_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] req_freq = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] prescaler;
  logic [15:0] period;
  logic        ok;

  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int quiet_cycles = 0;

  timer_setting_checker board = new();

  pwm_prescaler_period_solver_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_freq    (req_freq),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .prescaler   (prescaler),
    .period      (period),
    .ok          (ok)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (out_valid && !out_stall) begin
        board.check_setting(prescaler, period, ok);
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("pwm_prescaler_period_solver_unit_tb: done, errors");
    $finish;
  end

  task automatic send_request(input logic [31:0] freq);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_freq <= freq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(freq);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending_settings.size() != 0) @(posedge clk);
  endtask

  task automatic write_clock(input logic [31:0] value);
    wait_drained();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    board.clock_hz = value;
  endtask

  function automatic logic [31:0] pick_frequency(logic [31:0] c);
    logic [31:0] f;
    logic [63:0] b;
    logic [63:0] p;
    case ($urandom_range(0, 7))
      0: f = $urandom;
      1: f = $urandom >> $urandom_range(0, 31);
      2: f = c + $urandom_range(0, 2) - 1;
      3: f = $urandom_range(0, 1000);
      4: begin
        p = {32'd0, $urandom_range(0, 65535)};
        b = {32'd0, c} / ((COUNT_LIMIT + 64'd2) * (p + 64'd1));
        f = b[31:0] + $urandom_range(0, 2) - 1;
      end
      default: f = (c > 32'd1) ? $urandom_range(1, c) : 32'd1;
    endcase
    return f;
  endfunction

  function automatic logic [31:0] pick_clock();
    logic [31:0] c;
    case ($urandom_range(0, 5))
      0: c = 32'hFFFF_FFFF;
      1: c = $urandom_range(1, 200000);
      2: c = pps_pkg::CLK_RESET;
      default: c = $urandom;
    endcase
    return c;
  endfunction

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset clock: zero, prescaler step boundary, clock edge, all ones
    send_request(32'd0);
    send_request(32'd1);
    send_request(32'd1281);
    send_request(32'd1282);
    send_request(32'd50);
    send_request(32'd20000);
    send_request(32'd84000000);
    send_request(32'd84000001);
    send_request(32'hFFFF_FFFF);

    write_clock(32'hFFFF_FFFF);
    send_request(32'd1);
    send_request(32'd65535);
    send_request(32'd65536);
    send_request(32'h8000_0000);
    send_request(32'hFFFF_FFFF);

    write_clock(32'd1);
    send_request(32'd1);
    send_request(32'd2);

    // zero clock rejects any nonzero request
    write_clock(32'd0);
    send_request(32'd0);
    send_request(32'd1);

    write_clock(32'd65537);
    send_request(32'd1);
    send_request(32'd2);

    for (int ph = 0; ph < PHASES; ph++) begin
      write_clock(pick_clock());
      if (ph < 5) begin
        in_idle_pct = 31;
        out_idle_pct = 67;
      end else if (ph < 10) begin
        in_idle_pct = 67;
        out_idle_pct = 31;
      end else begin
        in_idle_pct = 0;
        out_idle_pct = 0;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 3 && i == PHASE_ITEMS / 2) wait_drained();
        send_request(pick_frequency(board.clock_hz));
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("pwm_prescaler_period_solver_unit_tb: done, clean");
    end else begin
      $display("pwm_prescaler_period_solver_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/pps_pkg.sv
hdl/pwm_prescaler_period_solver_unit.sv
tb/pwm_prescaler_period_solver_unit_tb.sv
